FILE: hdl/swam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swam_pkg: shared types and constants of the sensor window average monitor
// Sizes of the sensor table and the sample window, the reciprocal used for
// the window average, status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package swam_pkg;

  localparam int MAX_SENSORS = 32;
  localparam int WINDOW      = 5;

  localparam int ID_W      = 16;
  localparam int ROOM_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam int IDX_W      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W      = $clog2(MAX_SENSORS + 1);
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int RING_DEPTH = MAX_SENSORS * WINDOW;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // The running sum holds WINDOW samples; MAG_W covers its largest magnitude.
  localparam int MAG_W = $clog2(WINDOW * (2 ** (SAMPLE_W - 1)) + 1);
  localparam int SUM_W = MAG_W + 1;

  // floor(m / WINDOW) == (m * DIV_MULT) >> DIV_SHIFT for every m below 2**MAG_W.
  localparam int DIV_SHIFT  = MAG_W + $clog2(WINDOW);
  localparam int DIV_MULT_W = MAG_W + 1;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);
  localparam int PROD_W = MAG_W + DIV_MULT_W;

  localparam logic signed [CFG_W-1:0] MAX_TEMP_RESET = 16'sd7680;
  localparam logic signed [CFG_W-1:0] MIN_TEMP_RESET = 16'sd3840;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TEMP = 1'b0,
    CFG_MIN_TEMP = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REGISTERED = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FULL       = 3'd2,
    ST_UNKNOWN    = 3'd3,
    ST_FILLING    = 3'd4,
    ST_NORMAL     = 3'd5,
    ST_HOT        = 3'd6,
    ST_COLD       = 3'd7
  } status_t;

  // Which kind of result the datapath builds when the controller emits one.
  typedef enum logic [2:0] {
    RES_REGISTERED,
    RES_DUPLICATE,
    RES_FULL,
    RES_UNKNOWN,
    RES_FILLING,
    RES_JUDGE
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_ADD,
    S_FETCH,
    S_DUP,
    S_RING,
    S_UPDATE,
    S_ABS,
    S_MUL,
    S_JUDGE
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]        pos;
    logic [FILL_W-1:0]       fill;
    logic signed [SUM_W-1:0] wsum;
  } ent_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic add;
    logic fetch;
    logic ring_rd;
    logic update;
    logic absval;
    logic mul;
    logic emit;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic hit;
    logic free;
    logic op_sample;
    logic filling;
  } sts_t;

endpackage

FILE: hdl/swam_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swam_ctrl: sequencing controller
// Steps one item through search, then registration, or entry fetch, ring update
// and averaging, and tells the datapath when to emit a result and of which kind.
// ----------------------------------------------------------------------------
module swam_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  swam_pkg::sts_t sts,
  output swam_pkg::cmd_t cmd
);

  swam_pkg::state_t state_r;
  swam_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swam_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swam_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = swam_pkg::S_SCAN;
        end
      end
      swam_pkg::S_SCAN: begin
        if (sts.scan_done) begin
          if (sts.hit) begin
            state_nxt = swam_pkg::S_FETCH;
          end else if (!sts.op_sample && sts.free) begin
            state_nxt = swam_pkg::S_ADD;
          end else begin
            state_nxt = swam_pkg::S_IDLE;
          end
        end
      end
      swam_pkg::S_ADD:    state_nxt = swam_pkg::S_IDLE;
      swam_pkg::S_FETCH: begin
        state_nxt = sts.op_sample ? swam_pkg::S_RING : swam_pkg::S_DUP;
      end
      swam_pkg::S_DUP:    state_nxt = swam_pkg::S_IDLE;
      swam_pkg::S_RING:   state_nxt = swam_pkg::S_UPDATE;
      swam_pkg::S_UPDATE: begin
        state_nxt = sts.filling ? swam_pkg::S_IDLE : swam_pkg::S_ABS;
      end
      swam_pkg::S_ABS:    state_nxt = swam_pkg::S_MUL;
      swam_pkg::S_MUL:    state_nxt = swam_pkg::S_JUDGE;
      swam_pkg::S_JUDGE:  state_nxt = swam_pkg::S_IDLE;
      default:            state_nxt = swam_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.res = swam_pkg::RES_FULL;
    busy = (state_r != swam_pkg::S_IDLE);
    case (state_r)
      swam_pkg::S_IDLE: begin
        cmd.load = start;
      end
      swam_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        // A miss ends the item here unless a register item found a free slot.
        if (sts.scan_done && !sts.hit) begin
          if (sts.op_sample) begin
            cmd.emit = 1'b1;
            cmd.res  = swam_pkg::RES_UNKNOWN;
          end else if (!sts.free) begin
            cmd.emit = 1'b1;
            cmd.res  = swam_pkg::RES_FULL;
          end
        end
      end
      swam_pkg::S_ADD: begin
        cmd.add  = 1'b1;
        cmd.emit = 1'b1;
        cmd.res  = swam_pkg::RES_REGISTERED;
      end
      swam_pkg::S_FETCH: begin
        cmd.fetch = 1'b1;
      end
      swam_pkg::S_DUP: begin
        cmd.emit = 1'b1;
        cmd.res  = swam_pkg::RES_DUPLICATE;
      end
      swam_pkg::S_RING: begin
        cmd.ring_rd = 1'b1;
      end
      swam_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.filling) begin
          cmd.emit = 1'b1;
          cmd.res  = swam_pkg::RES_FILLING;
        end
      end
      swam_pkg::S_ABS: begin
        cmd.absval = 1'b1;
      end
      swam_pkg::S_MUL: begin
        cmd.mul = 1'b1;
      end
      swam_pkg::S_JUDGE: begin
        cmd.emit = 1'b1;
        cmd.res  = swam_pkg::RES_JUDGE;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/swam_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swam_dp: sensor table and averaging datapath
// Holds the id, room, entry and sample ring memories, the valid bits, the
// limit registers, the search pipeline, the reciprocal divider and the
// result registers.
// ----------------------------------------------------------------------------
module swam_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  swam_pkg::cmd_t                       cmd,
  output swam_pkg::sts_t                       sts,
  input  logic                                 in_operation,
  input  logic [swam_pkg::ID_W-1:0]            in_sensor_id,
  input  logic [swam_pkg::ROOM_W-1:0]          in_room_id,
  input  logic signed [swam_pkg::SAMPLE_W-1:0] in_sample_value,
  input  logic                                 cfg_we,
  input  logic [swam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swam_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 out_valid,
  output logic [swam_pkg::STATUS_W-1:0]        out_status,
  output logic [swam_pkg::ROOM_W-1:0]          out_room_out,
  output logic signed [swam_pkg::SAMPLE_W-1:0] out_average
);

  // Memories.
  logic [swam_pkg::ID_W-1:0]            id_mem   [swam_pkg::MAX_SENSORS];
  logic [swam_pkg::ROOM_W-1:0]          room_mem [swam_pkg::MAX_SENSORS];
  swam_pkg::ent_t                       ent_mem  [swam_pkg::MAX_SENSORS];
  logic signed [swam_pkg::SAMPLE_W-1:0] ring_mem [swam_pkg::RING_DEPTH];

  // Limits.
  logic signed [swam_pkg::CFG_W-1:0] max_r;
  logic signed [swam_pkg::CFG_W-1:0] min_r;

  // Latched item.
  logic                                 op_r;
  logic [swam_pkg::ID_W-1:0]            sid_r;
  logic [swam_pkg::ROOM_W-1:0]          rid_r;
  logic signed [swam_pkg::SAMPLE_W-1:0] smp_r;

  // Search.
  logic [swam_pkg::MAX_SENSORS-1:0] valid_r;
  logic [swam_pkg::CNT_W-1:0]       scan_cnt_r;
  logic                             cmp_vld_r;
  logic [swam_pkg::IDX_W-1:0]       cmp_idx_r;
  logic [swam_pkg::ID_W-1:0]        id_q_r;
  logic                             hit_r;
  logic [swam_pkg::IDX_W-1:0]       hit_idx_r;
  logic                             free_r;
  logic [swam_pkg::IDX_W-1:0]       free_idx_r;
  logic [swam_pkg::IDX_W-1:0]       scan_idx;
  logic                             id_match;

  // Entry and ring.
  logic [swam_pkg::ROOM_W-1:0]          room_q_r;
  swam_pkg::ent_t                       ent_q_r;
  logic signed [swam_pkg::SAMPLE_W-1:0] ring_q_r;
  logic [swam_pkg::RING_AW-1:0]         ring_addr;
  logic                                 win_full;
  logic signed [swam_pkg::SUM_W-1:0]    old_smp;
  swam_pkg::ent_t                       ent_nxt;

  // Averaging.
  logic signed [swam_pkg::SUM_W-1:0] sum_r;
  logic                              neg_r;
  logic [swam_pkg::MAG_W-1:0]        mag_r;
  logic [swam_pkg::PROD_W-1:0]       prod_r;
  logic [swam_pkg::SAMPLE_W-1:0]     quot;
  logic signed [swam_pkg::SAMPLE_W-1:0] avg_calc;
  swam_pkg::status_t                 judge_status;

  // Results.
  logic                                 out_valid_r;
  swam_pkg::status_t                    status_r;
  logic [swam_pkg::ROOM_W-1:0]          room_r;
  logic signed [swam_pkg::SAMPLE_W-1:0] avg_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= swam_pkg::MAX_TEMP_RESET;
      min_r <= swam_pkg::MIN_TEMP_RESET;
    end else if (cfg_we) begin
      case (swam_pkg::cfg_reg_t'(cfg_index))
        swam_pkg::CFG_MAX_TEMP: max_r <= cfg_data;
        swam_pkg::CFG_MIN_TEMP: min_r <= cfg_data;
        default: begin
          max_r <= max_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      sid_r <= in_sensor_id;
      rid_r <= in_room_id;
      smp_r <= in_sample_value;
    end
  end

  // Search pipeline: one id read issued per cycle, compared in the cycle after.
  assign scan_idx = scan_cnt_r[swam_pkg::IDX_W-1:0];
  assign id_match = valid_r[cmp_idx_r] && (id_q_r == sid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      scan_cnt_r <= '0;
      cmp_vld_r  <= 1'b0;
      hit_r      <= 1'b0;
      free_r     <= 1'b0;
      hit_idx_r  <= '0;
      free_idx_r <= '0;
    end else begin
      if (cmd.load) begin
        scan_cnt_r <= '0;
        cmp_vld_r  <= 1'b0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld_r <= (scan_cnt_r < swam_pkg::CNT_W'(swam_pkg::MAX_SENSORS));
        if (scan_cnt_r < swam_pkg::CNT_W'(swam_pkg::MAX_SENSORS)) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (cmp_vld_r && !hit_r && id_match) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
        if (cmp_vld_r && !free_r && !valid_r[cmp_idx_r]) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
      if (cmd.add) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      id_q_r    <= id_mem[scan_idx];
      cmp_idx_r <= scan_idx;
    end
    if (cmd.add) begin
      id_mem[free_idx_r] <= sid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      room_mem[free_idx_r] <= rid_r;
    end
    if (cmd.fetch) begin
      room_q_r <= room_mem[hit_idx_r];
    end
  end

  // Ring update.
  assign ring_addr = swam_pkg::RING_AW'(int'(hit_idx_r) * swam_pkg::WINDOW
                                        + int'(ent_q_r.pos));
  assign win_full  = (ent_q_r.fill == swam_pkg::FILL_W'(swam_pkg::WINDOW));
  assign old_smp   = win_full ? swam_pkg::SUM_W'(ring_q_r) : '0;

  always_comb begin
    ent_nxt.wsum = ent_q_r.wsum + swam_pkg::SUM_W'(smp_r) - old_smp;
    ent_nxt.fill = win_full ? ent_q_r.fill : ent_q_r.fill + 1'b1;
    if (ent_q_r.pos == swam_pkg::POS_W'(swam_pkg::WINDOW - 1)) begin
      ent_nxt.pos = '0;
    end else begin
      ent_nxt.pos = ent_q_r.pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      ent_mem[free_idx_r] <= '0;
    end else if (cmd.update) begin
      ent_mem[hit_idx_r] <= ent_nxt;
    end
    if (cmd.fetch) begin
      ent_q_r <= ent_mem[hit_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ring_rd) begin
      ring_q_r <= ring_mem[ring_addr];
    end
    if (cmd.update) begin
      ring_mem[ring_addr] <= smp_r;
    end
  end

  // Averaging: magnitude, reciprocal multiply, then restore the sign so the
  // quotient truncates toward zero.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sum_r <= ent_nxt.wsum;
    end
    if (cmd.absval) begin
      neg_r <= sum_r[swam_pkg::SUM_W-1];
      mag_r <= sum_r[swam_pkg::SUM_W-1] ? swam_pkg::MAG_W'(-sum_r)
                                        : swam_pkg::MAG_W'(sum_r);
    end
    if (cmd.mul) begin
      prod_r <= swam_pkg::PROD_W'(mag_r) * swam_pkg::PROD_W'(swam_pkg::DIV_MULT);
    end
  end

  assign quot     = prod_r[swam_pkg::DIV_SHIFT +: swam_pkg::SAMPLE_W];
  assign avg_calc = neg_r ? swam_pkg::SAMPLE_W'(-quot) : quot;

  always_comb begin
    // The hot test comes first, so it wins when the limits cross.
    if (avg_calc > max_r) begin
      judge_status = swam_pkg::ST_HOT;
    end else if (avg_calc < min_r) begin
      judge_status = swam_pkg::ST_COLD;
    end else begin
      judge_status = swam_pkg::ST_NORMAL;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.res)
        swam_pkg::RES_REGISTERED: begin
          status_r <= swam_pkg::ST_REGISTERED;
          room_r   <= rid_r;
          avg_r    <= '0;
        end
        swam_pkg::RES_DUPLICATE: begin
          status_r <= swam_pkg::ST_DUPLICATE;
          room_r   <= room_q_r;
          avg_r    <= '0;
        end
        swam_pkg::RES_UNKNOWN: begin
          status_r <= swam_pkg::ST_UNKNOWN;
          room_r   <= '0;
          avg_r    <= '0;
        end
        swam_pkg::RES_FILLING: begin
          status_r <= swam_pkg::ST_FILLING;
          room_r   <= room_q_r;
          avg_r    <= '0;
        end
        swam_pkg::RES_JUDGE: begin
          status_r <= judge_status;
          room_r   <= room_q_r;
          avg_r    <= avg_calc;
        end
        default: begin
          status_r <= swam_pkg::ST_FULL;
          room_r   <= '0;
          avg_r    <= '0;
        end
      endcase
    end
  end

  assign sts.scan_done = hit_r ||
    ((scan_cnt_r == swam_pkg::CNT_W'(swam_pkg::MAX_SENSORS)) && !cmp_vld_r);
  assign sts.hit       = hit_r;
  assign sts.free      = free_r;
  assign sts.op_sample = op_r;
  assign sts.filling   = (ent_q_r.fill < swam_pkg::FILL_W'(swam_pkg::WINDOW - 1));

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_room_out = room_r;
  assign out_average  = avg_r;

endmodule

FILE: hdl/sensor_window_average_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_window_average_monitor_core: per-sensor moving average monitor
// A table of registered sensors, each with a room and a ring of its latest
// samples. Register beats add sensors; sample beats update the ring and,
// once the window is full, report the average against two limits.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake         Payload                              Dir
//   -------   ---------------   ----------------------------------   ---
//   input     start / busy      in_operation, in_sensor_id,          in
//                               in_room_id, in_sample_value
//   result    out_valid strobe  out_status, out_room_out,            out
//                               out_average
//   config    cfg_we            cfg_index, cfg_data                  in
//
// A beat is taken at a clock edge with start high and busy low. The block
// then works on that one beat until it has emitted its single result.
// The sensor search reads one table entry per cycle and ends early on a
// match; a full sample beat then steps through entry fetch, ring read,
// ring update, magnitude, the averaging multiply and the judgement.
// The result shows for exactly one cycle with out_valid, in the cycle in
// which busy falls; the receiver cannot hold it off, and a new beat may be
// taken in that same cycle.
// Reset (rst_n low at a clock edge) clears the controller, the valid bits
// and the result strobe and restores the default limits; the table memories
// are not cleared, since an entry only counts once its valid bit is set.
//
module sensor_window_average_monitor_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input beats.
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_operation,
  input  logic [swam_pkg::ID_W-1:0]            in_sensor_id,
  input  logic [swam_pkg::ROOM_W-1:0]          in_room_id,
  input  logic signed [swam_pkg::SAMPLE_W-1:0] in_sample_value,
  // Results.
  output logic                                 out_valid,
  output logic [swam_pkg::STATUS_W-1:0]        out_status,
  output logic [swam_pkg::ROOM_W-1:0]          out_room_out,
  output logic signed [swam_pkg::SAMPLE_W-1:0] out_average,
  // Limit registers; the user must write them only while the block is idle; not enforced.
  input  logic                                 cfg_we,
  input  logic [swam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swam_pkg::CFG_W-1:0]           cfg_data
);

  // The controller holds only its state and issues commands; everything else
  // the block stores and computes lives in the datapath.
  swam_pkg::cmd_t cmd;
  swam_pkg::sts_t sts;

  swam_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  swam_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_sensor_id    (in_sensor_id),
    .in_room_id      (in_room_id),
    .in_sample_value (in_sample_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_room_out    (out_room_out),
    .out_average     (out_average)
  );

endmodule

FILE: test/tb_sensor_window_average_monitor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sensor_window_average_monitor_core: self-checking bench of the monitor
// Drives register and sample beats through the start/busy port. A shadow copy
// of the sensor table predicts every result, and each strobed result is
// compared with the oldest prediction. Directed checks cover limit edges,
// duplicates, unknown sensors, sample extremes, truncation and a full table.
// Random phases follow, each run under a different pair of limits.
// ----------------------------------------------------------------------------
module tb_sensor_window_average_monitor_core;
  import swam_pkg::*;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  // SETTLE_CYCLES is longer than the longest beat, so it is a safe settle time.
  localparam int SETTLE_CYCLES = 2 * MAX_SENSORS + 16;
  localparam int POOL_SIZE     = 40;
  localparam int PHASE_BEATS   = 200;

  typedef struct {
    status_t                    status;
    logic [ROOM_W-1:0]          room;
    logic signed [SAMPLE_W-1:0] average;
  } monitor_result_t;

  logic                       clk             = 1'b0;
  logic                       rst_n           = 1'b0;
  logic                       start           = 1'b0;
  logic                       busy;
  logic                       in_operation    = 1'b0;
  logic [ID_W-1:0]            in_sensor_id    = '0;
  logic [ROOM_W-1:0]          in_room_id      = '0;
  logic signed [SAMPLE_W-1:0] in_sample_value = '0;
  logic                       out_valid;
  logic [STATUS_W-1:0]        out_status;
  logic [ROOM_W-1:0]          out_room_out;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index       = '0;
  logic [CFG_W-1:0]           cfg_data        = '0;

  sensor_window_average_monitor_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_sensor_id    (in_sensor_id),
    .in_room_id      (in_room_id),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_room_out    (out_room_out),
    .out_average     (out_average),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the limits and the sensor table.
  logic signed [CFG_W-1:0]    hot_limit  = MAX_TEMP_RESET;
  logic signed [CFG_W-1:0]    cold_limit = MIN_TEMP_RESET;
  logic [ID_W-1:0]            shadow_id    [MAX_SENSORS];
  logic [ROOM_W-1:0]          shadow_room  [MAX_SENSORS];
  bit                         shadow_valid [MAX_SENSORS];
  logic signed [SAMPLE_W-1:0] shadow_ring  [MAX_SENSORS][WINDOW];
  int unsigned                shadow_pos   [MAX_SENSORS];
  int unsigned                shadow_fill  [MAX_SENSORS];
  int                         shadow_sum   [MAX_SENSORS];

  monitor_result_t pending_results[$];
  int              mismatches = 0;
  bit              gaps_on    = 1'b1;

  // Sensor ids that the random traffic keeps returning to, each with a
  // temperature trend so that windows drift hot, cold, stay in band or take random values.
  logic [ID_W-1:0] id_pool   [POOL_SIZE];
  int unsigned     pool_mode [POOL_SIZE];

  function automatic int shadow_lookup(input logic [ID_W-1:0] sid);
    for (int i = 0; i < MAX_SENSORS; i++)
      if (shadow_valid[i] && shadow_id[i] == sid) return i;
    return -1;
  endfunction

  // Applies one accepted beat to the shadow table and returns its result.
  function automatic monitor_result_t apply_beat(input logic op,
      input logic [ID_W-1:0] sid, input logic [ROOM_W-1:0] rid,
      input logic signed [SAMPLE_W-1:0] smp);
    monitor_result_t r;
    int e;
    int slot;
    int p;
    int avg;
    r.status  = ST_UNKNOWN;
    r.room    = '0;
    r.average = '0;
    e    = shadow_lookup(sid);
    slot = -1;
    if (op == OP_REGISTER) begin
      if (e >= 0) begin
        r.status = ST_DUPLICATE;
        r.room   = shadow_room[e];
      end else begin
        for (int i = 0; i < MAX_SENSORS; i++)
          if (!shadow_valid[i] && slot < 0) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          shadow_valid[slot] = 1'b1;
          shadow_id[slot]    = sid;
          shadow_room[slot]  = rid;
          shadow_pos[slot]   = 0;
          shadow_fill[slot]  = 0;
          shadow_sum[slot]   = 0;
          r.status = ST_REGISTERED;
          r.room   = rid;
        end
      end
    end else if (e >= 0) begin
      p = shadow_pos[e];
      // Until the window is full nothing drops out of the sum.
      if (shadow_fill[e] < WINDOW) shadow_fill[e]++;
      else shadow_sum[e] -= shadow_ring[e][p];
      shadow_ring[e][p] = smp;
      shadow_sum[e] += smp;
      shadow_pos[e] = (p + 1) % WINDOW;
      r.room = shadow_room[e];
      if (shadow_fill[e] < WINDOW) begin
        r.status = ST_FILLING;
      end else begin
        // Integer division truncates toward zero, as the block must.
        avg = shadow_sum[e] / WINDOW;
        if (avg > hot_limit) r.status = ST_HOT;
        else if (avg < cold_limit) r.status = ST_COLD;
        else r.status = ST_NORMAL;
        r.average = avg[SAMPLE_W-1:0];
      end
    end
    return r;
  endfunction

  // Presents one beat, holds it until the block takes it, then records
  // the result it should produce.
  task automatic send_beat(input logic op, input logic [ID_W-1:0] sid,
      input logic [ROOM_W-1:0] rid, input logic signed [SAMPLE_W-1:0] smp);
    @(posedge clk);
    while (gaps_on && $urandom_range(99) < 11) @(posedge clk);
    start           <= 1'b1;
    in_operation    <= op;
    in_sensor_id    <= sid;
    in_room_id      <= rid;
    in_sample_value <= smp;
    do @(posedge clk); while (busy !== 1'b0);
    start <= 1'b0;
    pending_results.push_back(apply_beat(op, sid, rid, smp));
  endtask

  task automatic fill_window(input logic [ID_W-1:0] sid,
      input logic signed [SAMPLE_W-1:0] smp);
    repeat (WINDOW) send_beat(OP_SAMPLE, sid, ROOM_W'($urandom()), smp);
  endtask

  task automatic wait_for_drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_reg_t idx, input logic signed [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_TEMP) hot_limit = value;
    else cold_limit = value;
  endtask

  // Limits change only once every outstanding result has come back.
  task automatic set_limits(input logic signed [CFG_W-1:0] hot,
      input logic signed [CFG_W-1:0] cold);
    wait_for_drain();
    write_limit(CFG_MAX_TEMP, hot);
    write_limit(CFG_MIN_TEMP, cold);
  endtask

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk) begin : check_results
    monitor_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing pending: status %0d room %h average %0d",
                   $time, out_status, out_room_out, out_average);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_room_out !== want.room ||
            out_average !== want.average) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: exp status %0d room %h average %0d, got %0d %h %0d",
                     $time, want.status, want.room, want.average, out_status,
                     out_room_out, out_average);
        end
      end
    end
  end

  // Reset limits: an average equal to the lower limit is normal, one below is cold.
  task automatic test_default_limits();
    send_beat(OP_REGISTER, 16'h0000, 16'h0000, 16'sh7FFF);
    fill_window(16'h0000, 16'sd3840);
    send_beat(OP_SAMPLE, 16'h0000, 16'h0000, 16'sd3835);
  endtask

  task automatic test_register_cases();
    send_beat(OP_REGISTER, 16'hFFFF, 16'hFFFF, 16'sh8000);
    // A second register keeps the stored room.
    send_beat(OP_REGISTER, 16'hFFFF, 16'h1234, 16'sh0000);
    send_beat(OP_SAMPLE, 16'h8001, 16'hFFFF, 16'sd100);
    send_beat(OP_REGISTER, 16'hA5A5, 16'h5A5A, 16'sh0000);
  endtask

  task automatic test_sample_extremes();
    fill_window(16'hFFFF, 16'sh7FFF);
    fill_window(16'hFFFF, -16'sd32768);
    // A sum of -7 must average to -1, not -2.
    send_beat(OP_SAMPLE, 16'hA5A5, 16'h0000, -16'sd3);
    send_beat(OP_SAMPLE, 16'hA5A5, 16'h0000, -16'sd2);
    send_beat(OP_SAMPLE, 16'hA5A5, 16'h0000, -16'sd1);
    send_beat(OP_SAMPLE, 16'hA5A5, 16'h0000, -16'sd1);
    send_beat(OP_SAMPLE, 16'hA5A5, 16'h0000, 16'sd0);
  endtask

  task automatic test_limit_extremes();
    set_limits(16'sh7FFF, -16'sd32768);
    send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 16'sh7FFF);
    // Crossed limits: the hot test comes first and wins.
    set_limits(-16'sd32768, 16'sh7FFF);
    send_beat(OP_SAMPLE, 16'hA5A5, 16'h0000, 16'sd500);
    send_beat(OP_SAMPLE, 16'hFFFF, 16'h0000, 16'sh7FFF);
  endtask

  task automatic send_random_beat();
    int unsigned k;
    int unsigned roll;
    int lo;
    int hi;
    int level;
    logic op;
    logic [ID_W-1:0] sid;
    k    = $urandom_range(POOL_SIZE - 1);
    roll = $urandom_range(99);
    sid  = id_pool[k];
    op   = OP_SAMPLE;
    if (roll < 10) begin
      op = OP_REGISTER;
    end else if (roll < 14) begin
      // Noise: any id, either operation.
      op  = 1'($urandom_range(1));
      sid = ID_W'($urandom());
    end
    if ($urandom_range(99) < 10) pool_mode[k] = $urandom_range(3);
    lo = (hot_limit < cold_limit) ? hot_limit : cold_limit;
    hi = (hot_limit < cold_limit) ? cold_limit : hot_limit;
    case (pool_mode[k])
      0:       level = (lo + hi) / 2;
      1:       level = hi + 300;
      2:       level = lo - 300;
      default: level = $signed(16'($urandom()));
    endcase
    level = level + int'($urandom_range(512)) - 256;
    if (level > 32767) level = 32767;
    if (level < -32768) level = -32768;
    send_beat(op, sid, ROOM_W'($urandom()), level[SAMPLE_W-1:0]);
  endtask

  // Random traffic in phases, each under its own limits. The last phase
  // runs without sender gaps.
  task automatic test_random_traffic();
    int lo;
    int hi;
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i]   = ID_W'($urandom());
      pool_mode[i] = $urandom_range(3);
    end
    for (int ph = 0; ph < 5; ph++) begin
      lo = int'($urandom_range(16000)) - 8000;
      hi = lo + int'($urandom_range(4000));
      case (ph)
        0:       set_limits(MAX_TEMP_RESET, MIN_TEMP_RESET);
        1:       set_limits(hi[CFG_W-1:0], lo[CFG_W-1:0]);
        2:       set_limits(16'sh7FFF, -16'sd32768);
        3:       set_limits(lo[CFG_W-1:0], hi[CFG_W-1:0]);
        default: set_limits(hi[CFG_W-1:0], lo[CFG_W-1:0]);
      endcase
      gaps_on = (ph != 4);
      repeat (PHASE_BEATS) send_random_beat();
    end
    gaps_on = 1'b1;
  endtask

  // Fills whatever room is left, then one more new sensor must be refused.
  task automatic test_table_full();
    int free_slots;
    logic [ID_W-1:0] fresh;
    free_slots = 0;
    fresh      = 16'h7000;
    for (int i = 0; i < MAX_SENSORS; i++)
      if (!shadow_valid[i]) free_slots++;
    for (int n = 0; n <= free_slots; n++) begin
      while (shadow_lookup(fresh) >= 0) fresh++;
      send_beat(OP_REGISTER, fresh, ~fresh, 16'sh0000);
      fresh++;
    end
    send_beat(OP_REGISTER, 16'hFFFF, 16'h0F0F, 16'sh0000);
    send_beat(OP_SAMPLE, 16'h0000, 16'hFFFF, 16'sd4000);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_default_limits();
    test_register_cases();
    test_sample_extremes();
    test_limit_extremes();
    test_random_traffic();
    test_table_full();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sensor_window_average_monitor_core.f
hdl/swam_pkg.sv
hdl/swam_ctrl.sv
hdl/swam_dp.sv
hdl/sensor_window_average_monitor_core.sv
test/tb_sensor_window_average_monitor_core.sv
